/* hdl/aes_block_encrypt_defines.svh */
// Assertion macros for the AES block encrypt design.
`ifndef AES_BLOCK_ENCRYPT_DEFINES_SVH
`define AES_BLOCK_ENCRYPT_DEFINES_SVH
`ifndef SYNTHESIS
`define AES_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define AES_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define AES_ASSERT_IMPL(label, clk, rst, ante, cons, msg)
`define AES_ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif
`endif

/* hdl/aes_pkg.sv */
// Shared types, constants and functions of the AES block encrypt design.
package aes_pkg;
   localparam int StoreDepth = 60;
   localparam int AddrW = 6;

   localparam logic [2:0] CSR_KEY_LENGTH = 3'd0;
   localparam logic [2:0] CSR_KEY_WORD_0 = 3'd1;
   localparam logic [2:0] CSR_KEY_WORD_3 = 3'd4;

   typedef logic [7:0] byte_type;
   typedef logic [127:0] block_type;

   function automatic byte_type sbox(input byte_type v);
      byte_type r;
      case (v)
         8'h00: r=8'h63; 8'h01: r=8'h7c; 8'h02: r=8'h77; 8'h03: r=8'h7b;
         8'h04: r=8'hf2; 8'h05: r=8'h6b; 8'h06: r=8'h6f; 8'h07: r=8'hc5;
         8'h08: r=8'h30; 8'h09: r=8'h01; 8'h0a: r=8'h67; 8'h0b: r=8'h2b;
         8'h0c: r=8'hfe; 8'h0d: r=8'hd7; 8'h0e: r=8'hab; 8'h0f: r=8'h76;
         8'h10: r=8'hca; 8'h11: r=8'h82; 8'h12: r=8'hc9; 8'h13: r=8'h7d;
         8'h14: r=8'hfa; 8'h15: r=8'h59; 8'h16: r=8'h47; 8'h17: r=8'hf0;
         8'h18: r=8'had; 8'h19: r=8'hd4; 8'h1a: r=8'ha2; 8'h1b: r=8'haf;
         8'h1c: r=8'h9c; 8'h1d: r=8'ha4; 8'h1e: r=8'h72; 8'h1f: r=8'hc0;
         8'h20: r=8'hb7; 8'h21: r=8'hfd; 8'h22: r=8'h93; 8'h23: r=8'h26;
         8'h24: r=8'h36; 8'h25: r=8'h3f; 8'h26: r=8'hf7; 8'h27: r=8'hcc;
         8'h28: r=8'h34; 8'h29: r=8'ha5; 8'h2a: r=8'he5; 8'h2b: r=8'hf1;
         8'h2c: r=8'h71; 8'h2d: r=8'hd8; 8'h2e: r=8'h31; 8'h2f: r=8'h15;
         8'h30: r=8'h04; 8'h31: r=8'hc7; 8'h32: r=8'h23; 8'h33: r=8'hc3;
         8'h34: r=8'h18; 8'h35: r=8'h96; 8'h36: r=8'h05; 8'h37: r=8'h9a;
         8'h38: r=8'h07; 8'h39: r=8'h12; 8'h3a: r=8'h80; 8'h3b: r=8'he2;
         8'h3c: r=8'heb; 8'h3d: r=8'h27; 8'h3e: r=8'hb2; 8'h3f: r=8'h75;
         8'h40: r=8'h09; 8'h41: r=8'h83; 8'h42: r=8'h2c; 8'h43: r=8'h1a;
         8'h44: r=8'h1b; 8'h45: r=8'h6e; 8'h46: r=8'h5a; 8'h47: r=8'ha0;
         8'h48: r=8'h52; 8'h49: r=8'h3b; 8'h4a: r=8'hd6; 8'h4b: r=8'hb3;
         8'h4c: r=8'h29; 8'h4d: r=8'he3; 8'h4e: r=8'h2f; 8'h4f: r=8'h84;
         8'h50: r=8'h53; 8'h51: r=8'hd1; 8'h52: r=8'h00; 8'h53: r=8'hed;
         8'h54: r=8'h20; 8'h55: r=8'hfc; 8'h56: r=8'hb1; 8'h57: r=8'h5b;
         8'h58: r=8'h6a; 8'h59: r=8'hcb; 8'h5a: r=8'hbe; 8'h5b: r=8'h39;
         8'h5c: r=8'h4a; 8'h5d: r=8'h4c; 8'h5e: r=8'h58; 8'h5f: r=8'hcf;
         8'h60: r=8'hd0; 8'h61: r=8'hef; 8'h62: r=8'haa; 8'h63: r=8'hfb;
         8'h64: r=8'h43; 8'h65: r=8'h4d; 8'h66: r=8'h33; 8'h67: r=8'h85;
         8'h68: r=8'h45; 8'h69: r=8'hf9; 8'h6a: r=8'h02; 8'h6b: r=8'h7f;
         8'h6c: r=8'h50; 8'h6d: r=8'h3c; 8'h6e: r=8'h9f; 8'h6f: r=8'ha8;
         8'h70: r=8'h51; 8'h71: r=8'ha3; 8'h72: r=8'h40; 8'h73: r=8'h8f;
         8'h74: r=8'h92; 8'h75: r=8'h9d; 8'h76: r=8'h38; 8'h77: r=8'hf5;
         8'h78: r=8'hbc; 8'h79: r=8'hb6; 8'h7a: r=8'hda; 8'h7b: r=8'h21;
         8'h7c: r=8'h10; 8'h7d: r=8'hff; 8'h7e: r=8'hf3; 8'h7f: r=8'hd2;
         8'h80: r=8'hcd; 8'h81: r=8'h0c; 8'h82: r=8'h13; 8'h83: r=8'hec;
         8'h84: r=8'h5f; 8'h85: r=8'h97; 8'h86: r=8'h44; 8'h87: r=8'h17;
         8'h88: r=8'hc4; 8'h89: r=8'ha7; 8'h8a: r=8'h7e; 8'h8b: r=8'h3d;
         8'h8c: r=8'h64; 8'h8d: r=8'h5d; 8'h8e: r=8'h19; 8'h8f: r=8'h73;
         8'h90: r=8'h60; 8'h91: r=8'h81; 8'h92: r=8'h4f; 8'h93: r=8'hdc;
         8'h94: r=8'h22; 8'h95: r=8'h2a; 8'h96: r=8'h90; 8'h97: r=8'h88;
         8'h98: r=8'h46; 8'h99: r=8'hee; 8'h9a: r=8'hb8; 8'h9b: r=8'h14;
         8'h9c: r=8'hde; 8'h9d: r=8'h5e; 8'h9e: r=8'h0b; 8'h9f: r=8'hdb;
         8'ha0: r=8'he0; 8'ha1: r=8'h32; 8'ha2: r=8'h3a; 8'ha3: r=8'h0a;
         8'ha4: r=8'h49; 8'ha5: r=8'h06; 8'ha6: r=8'h24; 8'ha7: r=8'h5c;
         8'ha8: r=8'hc2; 8'ha9: r=8'hd3; 8'haa: r=8'hac; 8'hab: r=8'h62;
         8'hac: r=8'h91; 8'had: r=8'h95; 8'hae: r=8'he4; 8'haf: r=8'h79;
         8'hb0: r=8'he7; 8'hb1: r=8'hc8; 8'hb2: r=8'h37; 8'hb3: r=8'h6d;
         8'hb4: r=8'h8d; 8'hb5: r=8'hd5; 8'hb6: r=8'h4e; 8'hb7: r=8'ha9;
         8'hb8: r=8'h6c; 8'hb9: r=8'h56; 8'hba: r=8'hf4; 8'hbb: r=8'hea;
         8'hbc: r=8'h65; 8'hbd: r=8'h7a; 8'hbe: r=8'hae; 8'hbf: r=8'h08;
         8'hc0: r=8'hba; 8'hc1: r=8'h78; 8'hc2: r=8'h25; 8'hc3: r=8'h2e;
         8'hc4: r=8'h1c; 8'hc5: r=8'ha6; 8'hc6: r=8'hb4; 8'hc7: r=8'hc6;
         8'hc8: r=8'he8; 8'hc9: r=8'hdd; 8'hca: r=8'h74; 8'hcb: r=8'h1f;
         8'hcc: r=8'h4b; 8'hcd: r=8'hbd; 8'hce: r=8'h8b; 8'hcf: r=8'h8a;
         8'hd0: r=8'h70; 8'hd1: r=8'h3e; 8'hd2: r=8'hb5; 8'hd3: r=8'h66;
         8'hd4: r=8'h48; 8'hd5: r=8'h03; 8'hd6: r=8'hf6; 8'hd7: r=8'h0e;
         8'hd8: r=8'h61; 8'hd9: r=8'h35; 8'hda: r=8'h57; 8'hdb: r=8'hb9;
         8'hdc: r=8'h86; 8'hdd: r=8'hc1; 8'hde: r=8'h1d; 8'hdf: r=8'h9e;
         8'he0: r=8'he1; 8'he1: r=8'hf8; 8'he2: r=8'h98; 8'he3: r=8'h11;
         8'he4: r=8'h69; 8'he5: r=8'hd9; 8'he6: r=8'h8e; 8'he7: r=8'h94;
         8'he8: r=8'h9b; 8'he9: r=8'h1e; 8'hea: r=8'h87; 8'heb: r=8'he9;
         8'hec: r=8'hce; 8'hed: r=8'h55; 8'hee: r=8'h28; 8'hef: r=8'hdf;
         8'hf0: r=8'h8c; 8'hf1: r=8'ha1; 8'hf2: r=8'h89; 8'hf3: r=8'h0d;
         8'hf4: r=8'hbf; 8'hf5: r=8'he6; 8'hf6: r=8'h42; 8'hf7: r=8'h68;
         8'hf8: r=8'h41; 8'hf9: r=8'h99; 8'hfa: r=8'h2d; 8'hfb: r=8'h0f;
         8'hfc: r=8'hb0; 8'hfd: r=8'h54; 8'hfe: r=8'hbb; default: r=8'h16;
      endcase
      return r;
   endfunction

   function automatic logic [31:0] sub_word(input logic [31:0] v);
      return {sbox(v[31:24]), sbox(v[23:16]), sbox(v[15:8]), sbox(v[7:0])};
   endfunction

   function automatic byte_type xtime(input byte_type v);
      return {v[6:0], 1'b0} ^ (v[7] ? 8'h1b : 8'h00);
   endfunction

   function automatic byte_type rcon(input logic [3:0] i);
      byte_type r;
      case (i)
         4'd1: r = 8'h01; 4'd2: r = 8'h02; 4'd3: r = 8'h04; 4'd4: r = 8'h08;
         4'd5: r = 8'h10; 4'd6: r = 8'h20; 4'd7: r = 8'h40; 4'd8: r = 8'h80;
         4'd9: r = 8'h1b; 4'd10: r = 8'h36; default: r = 8'h00;
      endcase
      return r;
   endfunction
endpackage

/* hdl/aes_block_encrypt.sv */
// AES encrypt top level: key expansion into a round key memory, iterative rounds.
// Nr = 10, 12 or 14 rounds; the rounds are paced by one round key word read from the memory
// per cycle, four reads per round.
// The input waits until the result is taken before it accepts the next item.
// After a key write, the first item also waits for the expansion of all 4*(Nr+1) key words.
// Reset (synchronous, active high) clears the key registers to a 128-bit zero key.
`include "aes_block_encrypt_defines.svh"
module aes_block_encrypt import aes_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [63:0] req_plain_high,
   input  logic [63:0] req_plain_low,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [63:0] rsp_cipher_high,
   output logic [63:0] rsp_cipher_low,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [63:0] csr_data
);
   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_EXP   = 4'b0010,
      ST_RUN   = 4'b0100,
      ST_OUT   = 4'b1000
   } state_type;

   state_type   st_ff, st_in;
   logic [1:0]  klen_ff;
   logic [63:0] kw_ff [4];
   logic        kready_ff;
   logic [3:0]  nr_ff;
   logic [5:0]  idx_ff, idx_in;
   logic [31:0] prev_ff;
   logic [31:0] hist_ff [8];
   logic [3:0]  rcnt_ff;
   logic [2:0]  kpos_ff;
   logic [3:0]  round_ff;
   logic [1:0]  col_ff;
   block_type   blk_ff, out_ff;
   logic [95:0] rk_ff;
   logic        out_valid_ff;
   logic        pend_ff;

   logic [31:0] mem [StoreDepth];
   logic [31:0] rd_ff;
   logic        we;
   logic [AddrW-1:0] wa, ra;
   logic [31:0] wd;

   logic [3:0]  nk;
   logic [5:0]  total;
   logic [31:0] t_word, rot;
   block_type   rnd_out;
   block_type   rkey;
   logic        last_rnd;
   logic        rd_ok;

   assign nk = (klen_ff == 2'd0) ? 4'd4 : (klen_ff == 2'd1) ? 4'd6 : 4'd8;
   assign total = 6'((nk + 4'd7) * 4);

   always_ff @(posedge clock) begin
      if (we) mem[wa] <= wd;
      rd_ff <= mem[ra];
   end

   always_comb begin
      rot = {prev_ff[23:0], prev_ff[31:24]};
      t_word = prev_ff;
      if (kpos_ff == 3'd0) begin
         t_word = sub_word(rot) ^ {rcon(rcnt_ff), 24'h0};
      end else if (nk == 4'd8 && kpos_ff == 3'd4) begin
         t_word = sub_word(prev_ff);
      end
   end

   always_comb begin
      we = 1'b0;
      wa = idx_ff;
      wd = hist_ff[0] ^ t_word;
      if (st_ff == ST_EXP) begin
         we = 1'b1;
         if (idx_ff < 6'(nk)) begin
            wd = idx_ff[0] ? kw_ff[idx_ff[2:1]][31:0] : kw_ff[idx_ff[2:1]][63:32];
         end
      end
   end

   assign ra = 6'({round_ff, col_ff});
   assign rd_ok = (st_ff == ST_RUN);
   assign rkey = {rk_ff, rd_ff};
   assign last_rnd = (round_ff == nr_ff + 4'd1);

   aes_round u_round (
      .state_i(blk_ff),
      .rkey_i (rkey),
      .last_i (last_rnd),
      .state_o(rnd_out)
   );

   assign req_ready = (st_ff == ST_IDLE) && !out_valid_ff;
   assign csr_ready = 1'b1;
   assign rsp_valid = out_valid_ff;
   assign rsp_cipher_high = out_ff[127:64];
   assign rsp_cipher_low  = out_ff[63:0];

   always_comb begin
      st_in = st_ff;
      idx_in = idx_ff;
      case (st_ff)
         ST_IDLE: begin
            idx_in = 6'd0;
            if (req_valid && req_ready) st_in = kready_ff ? ST_RUN : ST_EXP;
         end
         ST_EXP: begin
            idx_in = idx_ff + 6'd1;
            if (idx_ff == total - 6'd1) st_in = ST_RUN;
         end
         ST_RUN: if (pend_ff && last_rnd && col_ff == 2'd0) st_in = ST_OUT;
         ST_OUT: st_in = ST_IDLE;
         default: st_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= ST_IDLE;
         klen_ff <= 2'd0;
         for (int i = 0; i < 4; i++) kw_ff[i] <= 64'd0;
         kready_ff <= 1'b0;
         nr_ff <= 4'd10;
         out_valid_ff <= 1'b0;
         idx_ff <= 6'd0;
         round_ff <= 4'd0;
         col_ff <= 2'd0;
         pend_ff <= 1'b0;
      end else begin
         st_ff <= st_in;
         idx_ff <= idx_in;
         if (csr_valid) begin
            if (csr_index == CSR_KEY_LENGTH) begin
               klen_ff <= csr_data[1:0];
               kready_ff <= 1'b0;
            end else if (csr_index >= CSR_KEY_WORD_0 && csr_index <= CSR_KEY_WORD_3) begin
               kw_ff[2'(csr_index - CSR_KEY_WORD_0)] <= csr_data;
               kready_ff <= 1'b0;
            end
         end
         if (rsp_valid && rsp_ready) out_valid_ff <= 1'b0;
         case (st_ff)
            ST_IDLE: begin
               round_ff <= 4'd0;
               col_ff <= 2'd0;
               pend_ff <= 1'b0;
               kpos_ff <= 3'd0;
               rcnt_ff <= 4'd0;
               if (req_valid && req_ready) blk_ff <= {req_plain_high, req_plain_low};
            end
            ST_EXP: begin
               prev_ff <= wd;
               for (int i = 0; i < 7; i++) hist_ff[i] <= hist_ff[i+1];
               hist_ff[3'(nk - 4'd1)] <= wd;
               if (idx_ff == 6'(nk) - 6'd1 || kpos_ff == 3'(nk - 4'd1)) begin
                  kpos_ff <= 3'd0;
                  rcnt_ff <= rcnt_ff + 4'd1;
               end else begin
                  kpos_ff <= kpos_ff + 3'd1;
               end
               if (idx_ff == total - 6'd1) begin
                  kready_ff <= 1'b1;
                  nr_ff <= nk + 4'd6;
               end
            end
            ST_RUN: begin
               {round_ff, col_ff} <= {round_ff, col_ff} + 6'd1;
               pend_ff <= 1'b1;
               if (pend_ff) begin
                  rk_ff <= {rk_ff[63:0], rd_ff};
               end
               if (pend_ff && col_ff == 2'd0 && round_ff == 4'd1) begin
                  blk_ff <= blk_ff ^ rkey;
               end
               if (pend_ff && col_ff == 2'd0 && round_ff > 4'd1) begin
                  blk_ff <= rnd_out;
               end
               if (pend_ff && last_rnd && col_ff == 2'd0) begin
                  out_ff <= rnd_out;
               end
            end
            ST_OUT: out_valid_ff <= 1'b1;
            default: ;
         endcase
      end
   end

   `AES_ASSERT_IMPL(a_ready_idle, clock, reset, req_ready, st_ff == ST_IDLE, "ready outside idle")
   `AES_ASSERT_NEXT(a_exp_done, clock, reset, st_ff == ST_EXP && idx_ff == total - 6'd1, kready_ff || !rd_ok, "expansion end")
   `AES_ASSERT_NEXT(a_out_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(out_ff), "result dropped")
endmodule

/* hdl/aes_round.sv */
// One AES round: SubBytes, ShiftRows, optional MixColumns, AddRoundKey.
module aes_round import aes_pkg::*; (
   input  block_type  state_i,
   input  block_type  rkey_i,
   input  logic       last_i,
   output block_type  state_o
);
   byte_type s [16];
   byte_type t [16];
   byte_type m [16];
   block_type mixed;

   always_comb begin
      for (int i = 0; i < 16; i++) begin
         s[i] = state_i[127 - 8*i -: 8];
      end
      for (int c = 0; c < 4; c++) begin
         for (int r = 0; r < 4; r++) begin
            t[4*c + r] = sbox(s[4*((c + r) % 4) + r]);
         end
      end
      for (int c = 0; c < 4; c++) begin
         byte_type all;
         all = t[4*c] ^ t[4*c+1] ^ t[4*c+2] ^ t[4*c+3];
         m[4*c]   = t[4*c]   ^ all ^ xtime(t[4*c]   ^ t[4*c+1]);
         m[4*c+1] = t[4*c+1] ^ all ^ xtime(t[4*c+1] ^ t[4*c+2]);
         m[4*c+2] = t[4*c+2] ^ all ^ xtime(t[4*c+2] ^ t[4*c+3]);
         m[4*c+3] = t[4*c+3] ^ all ^ xtime(t[4*c+3] ^ t[4*c]);
      end
      for (int i = 0; i < 16; i++) begin
         mixed[127 - 8*i -: 8] = last_i ? t[i] : m[i];
      end
   end

   assign state_o = mixed ^ rkey_i;
endmodule

/* tb/tb_top.sv */
// Self-checking testbench for the AES block encrypt top level.
`timescale 1ns / 1ps
module tb_top import aes_pkg::*; ();

   localparam logic [2:0] CSR_KEY_WORD_1 = 3'd2;
   localparam logic [2:0] CSR_KEY_WORD_2 = 3'd3;
   localparam logic [2:0] CSR_UNUSED     = 3'd5;
   localparam int NUM_RANDOM = 1700;
   localparam int NUM_PHASES = 12;

   typedef struct {
      logic [63:0] ph;
      logic [63:0] pl;
      logic        known;
      logic [63:0] ch;
      logic [63:0] cl;
   } vec_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [63:0] req_plain_high = '0;
   logic [63:0] req_plain_low = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [63:0] rsp_cipher_high;
   logic [63:0] rsp_cipher_low;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [2:0]  csr_index = '0;
   logic [63:0] csr_data = '0;

   aes_block_encrypt i_dut (.*);

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   logic [1:0]  mdl_len;
   logic [63:0] mdl_key [4];
   logic [127:0] cipher_q [$];
   int          mismatches = 0;
   int          sent = 0;
   int          got = 0;
   bit          quiet = 1'b0;
   bit          done = 1'b0;

   localparam byte_type SBOX_TAB [256] = '{
      8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
      8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
      8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
      8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
      8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
      8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
      8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
      8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
      8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
      8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
      8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
      8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
      8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
      8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
      8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
      8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
   };

   function automatic logic [31:0] subst32(logic [31:0] v);
      return {SBOX_TAB[v[31:24]], SBOX_TAB[v[23:16]], SBOX_TAB[v[15:8]], SBOX_TAB[v[7:0]]};
   endfunction

   function automatic byte_type dbl(byte_type v);
      return {v[6:0], 1'b0} ^ (v[7] ? 8'h1b : 8'h00);
   endfunction

   function automatic logic [127:0] encrypt_block(logic [127:0] pt);
      logic [31:0] w [60];
      byte_type    s [16];
      byte_type    t [16];
      byte_type    rc [11];
      int          nk, nr, total;
      logic [31:0] tmp;
      byte_type    a0, a1, a2, a3, al;
      logic [127:0] res;
      rc = '{8'h00, 8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20, 8'h40, 8'h80, 8'h1b, 8'h36};
      nk = (mdl_len == 2'd0) ? 4 : (mdl_len == 2'd1) ? 6 : 8;
      nr = nk + 6;
      total = 4 * (nr + 1);
      for (int i = 0; i < nk; i++)
         w[i] = (i % 2) ? mdl_key[i / 2][31:0] : mdl_key[i / 2][63:32];
      for (int i = nk; i < total; i++) begin
         tmp = w[i - 1];
         if (i % nk == 0)
            tmp = subst32({tmp[23:0], tmp[31:24]}) ^ {rc[(i / nk) % 11], 24'h0};
         else if (nk > 6 && i % nk == 4)
            tmp = subst32(tmp);
         w[i] = w[i - nk] ^ tmp;
      end
      for (int i = 0; i < 16; i++) s[i] = pt[127 - 8 * i -: 8];
      for (int r = 0; r <= nr; r++) begin
         if (r > 0) begin
            for (int c = 0; c < 4; c++)
               for (int k = 0; k < 4; k++) t[4 * c + k] = SBOX_TAB[s[4 * ((c + k) % 4) + k]];
            s = t;
            if (r < nr) begin
               for (int c = 0; c < 4; c++) begin
                  a0 = s[4*c]; a1 = s[4*c+1]; a2 = s[4*c+2]; a3 = s[4*c+3];
                  al = a0 ^ a1 ^ a2 ^ a3;
                  s[4*c]   = a0 ^ al ^ dbl(a0 ^ a1);
                  s[4*c+1] = a1 ^ al ^ dbl(a1 ^ a2);
                  s[4*c+2] = a2 ^ al ^ dbl(a2 ^ a3);
                  s[4*c+3] = a3 ^ al ^ dbl(a3 ^ a0);
               end
            end
         end
         for (int c = 0; c < 4; c++)
            for (int k = 0; k < 4; k++) s[4 * c + k] ^= w[4 * r + c][31 - 8 * k -: 8];
      end
      for (int i = 0; i < 16; i++) res[127 - 8 * i -: 8] = s[i];
      return res;
   endfunction

   function automatic logic [63:0] rand64();
      case ($urandom_range(0, 7))
         0: return '0;
         1: return '1;
         default: return {$urandom, $urandom};
      endcase
   endfunction

   task automatic pause_maybe();
      if (!quiet && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 19)) @(posedge clock);
      end
   endtask

   task automatic csr_write(logic [2:0] idx, logic [63:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      do @(posedge clock); while (!csr_ready);
      if (idx == CSR_KEY_LENGTH) mdl_len = (val[1:0] == 2'd3) ? 2'd2 : val[1:0];
      else if (idx <= CSR_KEY_WORD_3) mdl_key[idx - 1] = val;
   endtask

   task automatic send_block(logic [63:0] ph, logic [63:0] pl, bit known,
                             logic [127:0] want);
      logic [127:0] pred;
      pred = encrypt_block({ph, pl});
      if (known && pred !== want) begin
         mismatches++;
         if (mismatches <= 10)
            $display("table row disagrees with predictor: %h vs %h", want, pred);
      end
      csr_valid      <= 1'b0;
      req_valid      <= 1'b1;
      req_plain_high <= ph;
      req_plain_low  <= pl;
      do @(posedge clock); while (!req_ready);
      cipher_q.push_back(known ? want : pred);
      sent++;
      pause_maybe();
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (cipher_q.size() != 0) @(posedge clock);
      repeat (60) @(posedge clock);
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (cipher_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected item %h %h", rsp_cipher_high, rsp_cipher_low);
         end else begin
            logic [127:0] exp_c;
            exp_c = cipher_q.pop_front();
            if (rsp_cipher_high !== exp_c[127:64] || rsp_cipher_low !== exp_c[63:0]) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: expected %h %h got %h %h", exp_c[127:64], exp_c[63:0],
                           rsp_cipher_high, rsp_cipher_low);
            end
         end
         got++;
      end
   end

   initial begin
      int idle_left;
      idle_left = 0;
      forever begin
         @(posedge clock);
         if (quiet || reset) rsp_ready <= 1'b1;
         else if (idle_left > 0) begin
            idle_left--;
            rsp_ready <= 1'b0;
         end else if ($urandom_range(0, 5) == 0) begin
            idle_left = $urandom_range(1, 19);
            rsp_ready <= 1'b0;
         end else rsp_ready <= 1'b1;
      end
   end

   vec_type table_rows [6];

   initial begin
      logic [127:0] ignore;
      ignore = '0;
      mdl_len = 2'd0;
      for (int i = 0; i < 4; i++) mdl_key[i] = '0;
      table_rows[0] = '{64'h0, 64'h0, 1'b1, 64'h66e94bd4ef8a2c3b, 64'h884cfa59ca342b2e};
      table_rows[1] = '{64'hffffffffffffffff, 64'hffffffffffffffff, 1'b0, 64'h0, 64'h0};
      table_rows[2] = '{64'h0123456789abcdef, 64'hfedcba9876543210, 1'b0, 64'h0, 64'h0};
      table_rows[3] = '{64'h8000000000000000, 64'h0, 1'b0, 64'h0, 64'h0};
      table_rows[4] = '{64'h0, 64'h1, 1'b0, 64'h0, 64'h0};
      table_rows[5] = '{64'haaaaaaaaaaaaaaaa, 64'h5555555555555555, 1'b0, 64'h0, 64'h0};
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (table_rows[i])
         send_block(table_rows[i].ph, table_rows[i].pl, table_rows[i].known,
                    {table_rows[i].ch, table_rows[i].cl});
      drain();

      csr_write(CSR_KEY_WORD_0, 64'h0001020304050607);
      csr_write(CSR_KEY_WORD_1, 64'h08090a0b0c0d0e0f);
      send_block(64'h0011223344556677, 64'h8899aabbccddeeff, 1'b1,
                 128'h69c4e0d86a7b0430d8cdb78070b4c55a);
      drain();
      csr_write(CSR_KEY_LENGTH, 64'd1);
      csr_write(CSR_KEY_WORD_2, 64'h1011121314151617);
      send_block(64'h0011223344556677, 64'h8899aabbccddeeff, 1'b1,
                 128'hdda97ca4864cdfe06eaf70a0ec0d7191);
      drain();
      csr_write(CSR_KEY_LENGTH, 64'd2);
      csr_write(CSR_KEY_WORD_3, 64'h18191a1b1c1d1e1f);
      send_block(64'h0011223344556677, 64'h8899aabbccddeeff, 1'b1,
                 128'h8ea2b7ca516745bfeafc49904b496089);
      drain();
      csr_write(CSR_KEY_LENGTH, 64'd3);
      send_block(64'h0011223344556677, 64'h8899aabbccddeeff, 1'b1,
                 128'h8ea2b7ca516745bfeafc49904b496089);
      drain();
      csr_write(CSR_UNUSED, 64'hffffffffffffffff);
      send_block('1, '0, 1'b0, ignore);
      drain();
      csr_write(CSR_KEY_LENGTH, 64'd0);
      for (int i = 0; i < 4; i++) csr_write(CSR_KEY_WORD_0 + 3'(i), '1);
      send_block('1, '1, 1'b0, ignore);
      send_block('0, '0, 1'b0, ignore);
      drain();

      for (int p = 0; p < NUM_PHASES; p++) begin
         csr_write(CSR_KEY_LENGTH, {62'd0, 2'($urandom_range(0, 3))});
         for (int i = 0; i < 4; i++)
            if ($urandom_range(0, 3) != 0) csr_write(CSR_KEY_WORD_0 + 3'(i), rand64());
         if ($urandom_range(0, 3) == 0) csr_write(CSR_UNUSED + 3'($urandom_range(0, 2)), rand64());
         if (p == NUM_PHASES - 1) quiet = 1'b1;
         for (int k = 0; k < NUM_RANDOM / NUM_PHASES; k++)
            send_block(rand64(), rand64(), 1'b0, ignore);
         drain();
      end

      if (mismatches == 0 && cipher_q.size() == 0 && got == sent)
         $display("[ OK ] regression clean");
      else $display("[FAIL] regression broken");
      done = 1'b1;
      $finish;
   end

   initial begin
      #20ms;
      if (!done) $display("[FAIL] regression broken");
      $finish;
   end
endmodule
